@@ src/rhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, defaults and types of the rgb to hsv converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 16;

	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int SAT_BITS_DEF = 16;

	// quotient bits resolved per divider stage
	localparam int DIV_STEP = 4;

	// front to back queue depth is 2**MID_AW
	localparam int MID_AW = 2;

	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} max_chan_t;

	typedef struct packed {
		logic grey;
		logic black;
	} pix_flags_t;

endpackage
`default_nettype wire

@@ src/rgb_to_hsv_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts an 8-bit rgb pixel to hue, saturation and brightness.
// ----------------------------------------------------------------------------
// One pixel is accepted and one result delivered per clock, sustained. A
// pushed pixel is classified at once and written into a four-word queue;
// the back end takes it from there into two radix-16 divider pipelines
// (hue and saturation) of ceil(max(17 + HUE_FRAC_BITS, 8 + SAT_BITS) / 4)
// stages, 6 at the default settings, and then into an output queue. The
// divider pipelines set the one-per-clock rate; the output queue is deep
// enough that a full stream never stalls as long as pop keeps up, and a
// stalled pop backs up into full without losing words.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int SAT_BITS = rhc_pkg::SAT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [rhc_pkg::CHAN_W-1:0] red,
	input  logic [rhc_pkg::CHAN_W-1:0] green,
	input  logic [rhc_pkg::CHAN_W-1:0] blue,
	output logic                       empty,
	input  logic                       pop,
	output logic [rhc_pkg::HUE_W-1:0]  hue,
	output logic [rhc_pkg::SAT_W-1:0]  saturation,
	output logic [rhc_pkg::CHAN_W-1:0] brightness
);
	import rhc_pkg::*;

	localparam int NH = 17 + HUE_FRAC_BITS;
	localparam int NS = CHAN_W + SAT_BITS;
	localparam int MID_W = NH + NS + 3 * CHAN_W + $bits(pix_flags_t);

	logic [NH-1:0]     f_hnum, m_hnum;
	logic [NS-1:0]     f_snum, m_snum;
	logic [CHAN_W-1:0] f_hdsr, f_sdsr, f_br, m_hdsr, m_sdsr, m_br;
	pix_flags_t        f_fl, m_fl;
	logic [MID_W-1:0]  mid_wdata, mid_rdata;
	logic              mid_empty, mid_pop;

	rhc_front #(.HUE_FRAC_BITS(HUE_FRAC_BITS), .SAT_BITS(SAT_BITS)) u_front (
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hue_num    (f_hnum),
		.sat_num    (f_snum),
		.hue_dsr    (f_hdsr),
		.sat_dsr    (f_sdsr),
		.brightness (f_br),
		.flags      (f_fl)
	);

	assign mid_wdata = {f_hnum, f_snum, f_hdsr, f_sdsr, f_br, f_fl};

	rhc_fifo #(.W(MID_W), .AW(MID_AW)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (mid_wdata),
		.rd     (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.full   (full)
	);

	assign {m_hnum, m_snum, m_hdsr, m_sdsr, m_br, m_fl} = mid_rdata;

	rhc_back #(.HUE_FRAC_BITS(HUE_FRAC_BITS), .SAT_BITS(SAT_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_empty  (mid_empty),
		.mid_pop    (mid_pop),
		.hue_num    (m_hnum),
		.sat_num    (m_snum),
		.hue_dsr    (m_hdsr),
		.sat_dsr    (m_sdsr),
		.bright_in  (m_br),
		.flags_in   (m_fl),
		.empty      (empty),
		.pop        (pop),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule
`default_nettype wire

@@ src/rhc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_fifo
// Small first-in first-out word queue with a fall-through head.
// ----------------------------------------------------------------------------
module rhc_fifo #(
	parameter int W = 8,
	parameter int AW = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);
	localparam int DEPTH = 2 ** AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

endmodule
`default_nettype wire

@@ src/rhc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_front
// Finds max, min and the dominant channel of a pixel and forms the hue and
// saturation dividends and divisors.
// ----------------------------------------------------------------------------
module rhc_front #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int SAT_BITS = rhc_pkg::SAT_BITS_DEF,
	localparam int NH = 17 + HUE_FRAC_BITS,
	localparam int NS = rhc_pkg::CHAN_W + SAT_BITS
) (
	input  logic [rhc_pkg::CHAN_W-1:0] red,
	input  logic [rhc_pkg::CHAN_W-1:0] green,
	input  logic [rhc_pkg::CHAN_W-1:0] blue,
	output logic [NH-1:0]              hue_num,
	output logic [NS-1:0]              sat_num,
	output logic [rhc_pkg::CHAN_W-1:0] hue_dsr,
	output logic [rhc_pkg::CHAN_W-1:0] sat_dsr,
	output logic [rhc_pkg::CHAN_W-1:0] brightness,
	output rhc_pkg::pix_flags_t        flags
);
	import rhc_pkg::*;

	max_chan_t         sel;
	logic [CHAN_W-1:0] mx, mn, dl;
	logic [10:0]       x;
	logic [16:0]       x60;

	always_comb begin
		// ties go to red, then green
		if (red >= green && red >= blue) begin
			sel = MAX_RED;
		end else if (green >= blue) begin
			sel = MAX_GREEN;
		end else begin
			sel = MAX_BLUE;
		end

		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end

		case (sel)
			MAX_RED: begin
				mx = red;
			end
			MAX_GREEN: begin
				mx = green;
			end
			MAX_BLUE: begin
				mx = blue;
			end
			default: begin
				mx = red;
			end
		endcase
		dl = mx - mn;

		// sextant offset scaled by delta, always non-negative
		case (sel)
			MAX_RED: begin
				if (green >= blue) begin
					x = 11'(green - blue);
				end else begin
					// negative angle wraps by six sextants
					x = (11'(dl) << 2) + (11'(dl) << 1) - 11'(blue - green);
				end
			end
			MAX_GREEN: begin
				x = 11'(blue) + (11'(dl) << 1) - 11'(red);
			end
			MAX_BLUE: begin
				x = 11'(red) + (11'(dl) << 2) - 11'(green);
			end
			default: begin
				x = '0;
			end
		endcase
	end

	assign x60     = (17'(x) << 6) - (17'(x) << 2);
	assign hue_num = NH'(x60) << HUE_FRAC_BITS;
	assign sat_num = NS'(dl) << SAT_BITS;

	assign flags.grey  = (dl == '0);
	assign flags.black = (mx == '0);
	assign hue_dsr     = flags.grey ? CHAN_W'(1) : dl;
	assign sat_dsr     = flags.black ? CHAN_W'(1) : mx;
	assign brightness  = mx;

endmodule
`default_nettype wire

@@ src/rhc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider by an 8-bit divisor, DIV_STEP quotient bits per
// stage, one new division every clock.
// ----------------------------------------------------------------------------
module rhc_div #(
	parameter int NW = 24,
	localparam int NST = (NW + rhc_pkg::DIV_STEP - 1) / rhc_pkg::DIV_STEP,
	localparam int PW = NST * rhc_pkg::DIV_STEP
) (
	input  logic                      clk,
	input  logic [NW-1:0]             dividend,
	input  logic [rhc_pkg::CHAN_W-1:0] divisor,
	output logic [NW-1:0]             quotient
);
	import rhc_pkg::*;

	logic [PW-1:0]     dvd_s [NST];
	logic [PW-1:0]     quo_s [NST];
	logic [CHAN_W-1:0] rem_s [NST];
	logic [CHAN_W-1:0] dsr_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic [PW-1:0]     dvd_i, quo_i, dvd_o, quo_o;
		logic [CHAN_W-1:0] rem_i, dsr_i, rem_o;

		if (g == 0) begin : g_first
			assign dvd_i = PW'(dividend);
			assign quo_i = '0;
			assign rem_i = '0;
			assign dsr_i = divisor;
		end else begin : g_next
			assign dvd_i = dvd_s[g-1];
			assign quo_i = quo_s[g-1];
			assign rem_i = rem_s[g-1];
			assign dsr_i = dsr_s[g-1];
		end

		always_comb begin : p_step
			logic [CHAN_W:0]   t;
			logic [CHAN_W-1:0] r;
			logic [PW-1:0]     q, dv;
			r  = rem_i;
			q  = quo_i;
			dv = dvd_i;
			for (int i = 0; i < DIV_STEP; i++) begin
				t  = {r, dv[PW-1]};
				dv = dv << 1;
				if (t >= {1'b0, dsr_i}) begin
					r = CHAN_W'(t - {1'b0, dsr_i});
					q = {q[PW-2:0], 1'b1};
				end else begin
					r = t[CHAN_W-1:0];
					q = {q[PW-2:0], 1'b0};
				end
			end
			dvd_o = dv;
			quo_o = q;
			rem_o = r;
		end

		always_ff @(posedge clk) begin
			dvd_s[g] <= dvd_o;
			quo_s[g] <= quo_o;
			rem_s[g] <= rem_o;
			dsr_s[g] <= dsr_i;
		end
	end

	assign quotient = quo_s[NST-1][NW-1:0];

endmodule
`default_nettype wire

@@ src/rhc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_back
// Issues queued pixels into the hue and saturation dividers, finishes the
// results and holds them in an output queue guarded by a credit count.
// ----------------------------------------------------------------------------
module rhc_back #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int SAT_BITS = rhc_pkg::SAT_BITS_DEF,
	localparam int NH = 17 + HUE_FRAC_BITS,
	localparam int NS = rhc_pkg::CHAN_W + SAT_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       mid_empty,
	output logic                       mid_pop,
	input  logic [NH-1:0]              hue_num,
	input  logic [NS-1:0]              sat_num,
	input  logic [rhc_pkg::CHAN_W-1:0] hue_dsr,
	input  logic [rhc_pkg::CHAN_W-1:0] sat_dsr,
	input  logic [rhc_pkg::CHAN_W-1:0] bright_in,
	input  rhc_pkg::pix_flags_t        flags_in,
	output logic                       empty,
	input  logic                       pop,
	output logic [rhc_pkg::HUE_W-1:0]  hue,
	output logic [rhc_pkg::SAT_W-1:0]  saturation,
	output logic [rhc_pkg::CHAN_W-1:0] brightness
);
	import rhc_pkg::*;

	localparam int NW = (NH > NS) ? NH : NS;
	localparam int NST = (NW + DIV_STEP - 1) / DIV_STEP;
	localparam int OUT_AW = $clog2(NST + 2);
	localparam int OUT_DEPTH = 2 ** OUT_AW;
	localparam int CW = $clog2(OUT_DEPTH + 1);
	localparam int OUT_W = HUE_W + SAT_W + CHAN_W;
	localparam logic [NW-1:0] SAT_MAX = (NW'(1) << SAT_BITS) - NW'(1);

	logic              issue, out_pop, out_full;
	logic [CW-1:0]     cnt_q;
	logic              v_s   [NST];
	logic [CHAN_W-1:0] br_s  [NST];
	pix_flags_t        fl_s  [NST];
	logic [NW-1:0]     hq, sq, sclip;
	logic [HUE_W-1:0]  hue_r;
	logic [OUT_W-1:0]  res_w, out_w;

	// credit covers words in the dividers plus words in the output queue
	assign out_pop = pop && !empty;
	assign issue   = !mid_empty && (cnt_q < CW'(OUT_DEPTH));
	assign mid_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(issue) - CW'(out_pop);
		end
	end

	rhc_div #(.NW(NW)) u_hue_div (
		.clk      (clk),
		.dividend (NW'(hue_num)),
		.divisor  (hue_dsr),
		.quotient (hq)
	);

	rhc_div #(.NW(NW)) u_sat_div (
		.clk      (clk),
		.dividend (NW'(sat_num)),
		.divisor  (sat_dsr),
		.quotient (sq)
	);

	for (genvar g = 0; g < NST; g++) begin : g_line
		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[g] <= 1'b0;
				end else begin
					v_s[g] <= issue;
				end
			end
			always_ff @(posedge clk) begin
				br_s[g] <= bright_in;
				fl_s[g] <= flags_in;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[g] <= 1'b0;
				end else begin
					v_s[g] <= v_s[g-1];
				end
			end
			always_ff @(posedge clk) begin
				br_s[g] <= br_s[g-1];
				fl_s[g] <= fl_s[g-1];
			end
		end
	end

	always_comb begin
		hue_r = fl_s[NST-1].grey ? '0 : hq[HUE_W-1:0];
		if (fl_s[NST-1].black) begin
			sclip = '0;
		end else if ((sq >> SAT_BITS) != '0) begin
			// delta equal to max gives exactly one, clipped to all ones
			sclip = SAT_MAX;
		end else begin
			sclip = sq;
		end
		res_w = {hue_r, sclip[SAT_W-1:0], br_s[NST-1]};
	end

	rhc_fifo #(.W(OUT_W), .AW(OUT_AW)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (v_s[NST-1]),
		.wdata  (res_w),
		.rd     (out_pop),
		.rdata  (out_w),
		.empty  (empty),
		.full   (out_full)
	);

	assign {hue, saturation, brightness} = out_w;

	// credit keeps the output queue from filling past its depth
	logic unused_full;
	assign unused_full = out_full;

endmodule
`default_nettype wire

@@ src/rhc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the rgb to hsv converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker #(
	parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int SAT_BITS = rhc_pkg::SAT_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       push,
	input logic                       full,
	input logic [rhc_pkg::CHAN_W-1:0] red,
	input logic [rhc_pkg::CHAN_W-1:0] green,
	input logic [rhc_pkg::CHAN_W-1:0] blue,
	input logic                       empty,
	input logic                       pop,
	input logic [rhc_pkg::HUE_W-1:0]  hue,
	input logic [rhc_pkg::SAT_W-1:0]  saturation,
	input logic [rhc_pkg::CHAN_W-1:0] brightness
);
	localparam bit HUE_CHK = (HUE_FRAC_BITS <= 6);
	localparam int HUE_LIMIT = 360 << HUE_FRAC_BITS;
	localparam bit GREY_CHK = (SAT_BITS <= 16);

	logic unused_in;
	assign unused_in = ^{push, full, red, green, blue};

	// no word shows while reset holds
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty in reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("stalled result word changed");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && brightness == '0 |-> saturation == '0)
		else $error("black pixel with nonzero saturation");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		GREY_CHK && !empty && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		HUE_CHK && !empty |-> int'(hue) < HUE_LIMIT)
		else $error("hue beyond full circle");

endmodule

bind rgb_to_hsv_converter rhc_checker #(
	.HUE_FRAC_BITS(HUE_FRAC_BITS),
	.SAT_BITS(SAT_BITS)
) u_rhc_checker (.*);
`default_nettype wire
